FILE: src/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package u16u8_pkg;

    // Byte order mode register codes; any other value detects from the mark.
    localparam logic [1:0] MODE_LE     = 2'd0;
    localparam logic [1:0] MODE_BE     = 2'd1;
    localparam logic [1:0] MODE_DETECT = 2'd2;

    localparam logic [15:0] BOM_NATIVE  = 16'hfeff;
    localparam logic [15:0] BOM_SWAPPED = 16'hfffe;
    localparam logic [15:0] LOW_SURR_BASE = 16'hdc00;
    localparam logic [10:0] SUPP_OFFSET   = 11'h040;

    localparam logic [7:0] REPL_B0 = 8'hef;
    localparam logic [7:0] REPL_B1 = 8'hbf;
    localparam logic [7:0] REPL_B2 = 8'hbd;

    localparam int QUEUE_DEPTH_DEF = 2;

    // One encoded unit: up to four bytes, sent from index 0 upward.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            string_end;
    } job_t;

endpackage

`default_nettype wire

FILE: src/u16u8_front.sv
// Front end: takes input words, tracks byte order and held surrogates,
// and turns each unit into an encoded job. Depends on u16u8_pkg.
`default_nettype none

module u16u8_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [1:0]        mode,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [15:0]       code_unit,
    input  wire logic              first_unit,
    input  wire logic              last_unit,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output u16u8_pkg::job_t        job
);

    logic       be_reg, be_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [9:0] pend_high_reg, pend_high_next;

    logic        mark, be_first, be_eff, pend_eff, drop, store_high, accept;
    logic [15:0] c, lo;
    logic [10:0] h;

    always_comb
    begin
        mark = (code_unit == u16u8_pkg::BOM_NATIVE) || (code_unit == u16u8_pkg::BOM_SWAPPED);
        case (mode)
            u16u8_pkg::MODE_LE: be_first = 1'b0;
            u16u8_pkg::MODE_BE: be_first = 1'b1;
            default:            be_first = mark ? (code_unit == u16u8_pkg::BOM_SWAPPED) : 1'b1;
        endcase
        be_eff   = first_unit ? be_first : be_reg;
        pend_eff = first_unit ? 1'b0 : pend_valid_reg;
        drop     = first_unit && mark;
        c        = be_eff ? {code_unit[7:0], code_unit[15:8]} : code_unit;
        h        = {1'b0, pend_high_reg} + u16u8_pkg::SUPP_OFFSET;
        lo       = c - u16u8_pkg::LOW_SURR_BASE;

        store_high      = 1'b0;
        job.string_end  = last_unit;
        job.bytes       = '0;
        job.last_idx    = 2'd0;
        if (pend_eff)
        begin
            // The unit after a high surrogate is joined without any check.
            job.bytes[0] = 8'hf0 | {5'h00, h[10:8]};
            job.bytes[1] = {2'b10, h[7:2]};
            job.bytes[2] = {2'b10, h[1:0], 4'h0} | lo[13:6];
            job.bytes[3] = {2'b10, lo[5:0]};
            job.last_idx = 2'd3;
        end
        else if (c < 16'h0080)
        begin
            job.bytes[0] = c[7:0];
            job.last_idx = 2'd0;
        end
        else if (c < 16'h0800)
        begin
            job.bytes[0] = {3'b110, c[10:6]};
            job.bytes[1] = {2'b10, c[5:0]};
            job.last_idx = 2'd1;
        end
        else if (c[15:11] != 5'b11011)
        begin
            job.bytes[0] = {4'he, c[15:12]};
            job.bytes[1] = {2'b10, c[11:6]};
            job.bytes[2] = {2'b10, c[5:0]};
            job.last_idx = 2'd2;
        end
        else if (c[15:10] == 6'b110110 && !last_unit)
        begin
            store_high = 1'b1;
        end
        else
        begin
            job.bytes[0] = u16u8_pkg::REPL_B0;
            job.bytes[1] = u16u8_pkg::REPL_B1;
            job.bytes[2] = u16u8_pkg::REPL_B2;
            job.last_idx = 2'd2;
        end

        in_ready  = job_ready;
        accept    = in_valid && in_ready;
        job_valid = in_valid && !drop && !store_high;

        be_next         = be_reg;
        pend_valid_next = pend_valid_reg;
        pend_high_next  = pend_high_reg;
        if (accept)
        begin
            be_next         = be_eff;
            pend_valid_next = store_high && !drop;
            pend_high_next  = store_high ? c[9:0] : 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            be_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_high_reg  <= 10'd0;
        end
        else
        begin
            be_reg         <= be_next;
            pend_valid_reg <= pend_valid_next;
            pend_high_reg  <= pend_high_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/u16u8_queue.sv
// Short job queue between the front and back ends.
// Depends on u16u8_pkg for the job type.
`default_nettype none

module u16u8_queue
#(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire u16u8_pkg::job_t   push_job,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output u16u8_pkg::job_t        pop_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    u16u8_pkg::job_t entries [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    always_comb
    begin
        push_ready = (count_reg != CW'(DEPTH));
        pop_valid  = (count_reg != '0);
        pop_job    = entries[rd_ptr_reg];
        do_push    = push_valid && push_ready;
        do_pop     = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/u16u8_back.sv
// Back end: serializes queued jobs through a registered output stage into one
// output word per cycle while the output is ready. Depends on u16u8_pkg.
`default_nettype none

module u16u8_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  wire u16u8_pkg::job_t   job,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   run_end,
    output logic                   string_end
);

    u16u8_pkg::job_t cur_reg, cur_next;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       ovalid_reg, ovalid_next;
    logic [7:0] obyte_reg, obyte_next;
    logic       orun_reg, orun_next, ostr_reg, ostr_next;
    logic       out_free, emit, tail;

    always_comb
    begin
        out_free = !ovalid_reg || out_ready;
        emit     = busy_reg && out_free;
        tail     = (idx_reg == cur_reg.last_idx);
        // A new job loads as the current one sends its final byte.
        job_ready = !busy_reg || (emit && tail);

        cur_next    = cur_reg;
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg && !out_ready;
        obyte_next  = obyte_reg;
        orun_next   = orun_reg;
        ostr_next   = ostr_reg;

        if (emit)
        begin
            ovalid_next = 1'b1;
            obyte_next  = cur_reg.bytes[idx_reg];
            orun_next   = tail;
            ostr_next   = tail && cur_reg.string_end;
            idx_next    = idx_reg + 2'd1;
            if (tail)
                busy_next = 1'b0;
        end
        if (job_ready && job_valid)
        begin
            cur_next  = job;
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        obyte_reg <= obyte_next;
        orun_reg  <= orun_next;
        ostr_reg  <= ostr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_byte   = obyte_reg;
    assign run_end    = orun_reg;
    assign string_end = ostr_reg;

endmodule

`default_nettype wire

FILE: src/utf16_to_utf8_encoder_core.sv
// UTF-16 to UTF-8 encoder: one code unit per input word, one UTF-8 byte per
// output word. The output is the bottleneck: each unit yields 1 to 3 bytes
// (a surrogate pair 4 on its second unit, a byte order mark or a held high
// surrogate none). A small job queue lets input be taken while earlier bytes
// are still being sent. The user must write the byte order mode through the
// cfg port only while the block is idle; the block does not enforce this.
`default_nettype none

module utf16_to_utf8_encoder_core
#(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,    // byte_order_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,     // code_unit[15:0]
    input  wire logic        s_tuser,     // first_unit
    input  wire logic        s_tlast,     // last_unit
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,     // out_byte[7:0]
    output logic             m_tuser,     // run_end
    output logic             m_tlast      // string_end
);

    logic [1:0] mode_reg;
    logic       fq_valid, fq_ready, qb_valid, qb_ready;
    u16u8_pkg::job_t fq_job, qb_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= u16u8_pkg::MODE_DETECT;
        else if (cfg_valid)
            mode_reg <= cfg_data;
    end

    u16u8_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .code_unit  (s_tdata),
        .first_unit (s_tuser),
        .last_unit  (s_tlast),
        .job_valid  (fq_valid),
        .job_ready  (fq_ready),
        .job        (fq_job)
    );

    u16u8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    u16u8_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (qb_valid),
        .job_ready  (qb_ready),
        .job        (qb_job),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .run_end    (m_tuser),
        .string_end (m_tlast)
    );

endmodule

`default_nettype wire

FILE: test/tb_utf16_to_utf8_encoder_core.sv
// Self-checking testbench for the UTF-16 to UTF-8 encoder core.
// It needs u16u8_pkg and utf16_to_utf8_encoder_core; each output byte is checked
// against a predictor in this file or against bytes typed in a directed row.
module tb_utf16_to_utf8_encoder_core;

    timeunit 1ns;
    timeprecision 1ps;

    // Mode value three is not named in the package and behaves like detect mode.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int IDLE_LIMIT     = 5000;
    localparam int PHASE_WORDS    = 63;
    localparam int PRINT_LIMIT    = 30;
    localparam int FROM_PREDICTOR = -1;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       string_end;
    } utf8_byte_t;

    typedef struct {
        logic [15:0] unit;
        logic        first;
        logic        last;
        int          typed_count;
        logic [23:0] typed_bytes;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = 2'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;   // code_unit[15:0]
    logic        s_tuser = 1'b0;    // first_unit
    logic        s_tlast = 1'b0;    // last_unit
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // out_byte[7:0]
    logic        m_tuser;           // run_end
    logic        m_tlast;           // string_end

    // Predictor state: a copy of what the block keeps between words.
    logic [1:0]  byte_order_mode = u16u8_pkg::MODE_DETECT;
    logic [9:0]  held_high = 10'd0;
    logic        held_valid = 1'b0;
    logic        swap_now = 1'b0;

    utf8_byte_t  utf8_expected [$];
    int          units_sent = 0;
    int          bytes_checked = 0;
    int          mismatches = 0;
    int          long_holds = 0;
    logic        hold_request = 1'b0;
    logic        sender_burst = 1'b0;

    stim_row_t   directed_rows [22];

    utf16_to_utf8_encoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
        begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
    endtask

    // Encodes one code unit and updates the predictor state; returns the byte count.
    function automatic int encode_unit(input logic [15:0] unit, input logic first,
                                       input logic last, output logic [3:0][7:0] enc);
        logic        is_mark;
        logic [15:0] cu;
        logic [10:0] plane;
        logic [15:0] low_part;
        enc = '0;
        if (first)
        begin
            is_mark = (unit == u16u8_pkg::BOM_NATIVE) || (unit == u16u8_pkg::BOM_SWAPPED);
            held_valid = 1'b0;
            held_high = 10'd0;
            case (byte_order_mode)
                u16u8_pkg::MODE_LE: swap_now = 1'b0;
                u16u8_pkg::MODE_BE: swap_now = 1'b1;
                default: swap_now = is_mark ? (unit == u16u8_pkg::BOM_SWAPPED) : 1'b1;
            endcase
            if (is_mark)
            begin
                return 0;
            end
        end
        cu = swap_now ? {unit[7:0], unit[15:8]} : unit;
        if (held_valid)
        begin
            plane = {1'b0, held_high} + u16u8_pkg::SUPP_OFFSET;
            low_part = cu - u16u8_pkg::LOW_SURR_BASE;
            enc[0] = 8'hf0 | {5'd0, plane[10:8]};
            enc[1] = {2'b10, plane[7:2]};
            enc[2] = 8'h80 | {2'b00, plane[1:0], 4'd0} | low_part[13:6];
            enc[3] = {2'b10, low_part[5:0]};
            held_valid = 1'b0;
            held_high = 10'd0;
            return 4;
        end
        if (cu < 16'h0080)
        begin
            enc[0] = cu[7:0];
            return 1;
        end
        if (cu < 16'h0800)
        begin
            enc[0] = {3'b110, cu[10:6]};
            enc[1] = {2'b10, cu[5:0]};
            return 2;
        end
        if (cu < 16'hd800 || cu >= 16'he000)
        begin
            enc[0] = {4'b1110, cu[15:12]};
            enc[1] = {2'b10, cu[11:6]};
            enc[2] = {2'b10, cu[5:0]};
            return 3;
        end
        if (cu < u16u8_pkg::LOW_SURR_BASE && !last)
        begin
            held_high = cu[9:0];
            held_valid = 1'b1;
            return 0;
        end
        // A lone low surrogate or a high surrogate that ends the string.
        enc[0] = u16u8_pkg::REPL_B0;
        enc[1] = u16u8_pkg::REPL_B1;
        enc[2] = u16u8_pkg::REPL_B2;
        return 3;
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_burst || r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    // Offers one word, waits for it to be taken and queues the bytes it must yield.
    // A typed count of zero or more replaces the predicted bytes with the typed ones.
    task automatic send_word(input logic [15:0] unit, input logic first, input logic last,
                             input int typed_count, input logic [23:0] typed_bytes);
        int                gap;
        int                count;
        logic [3:0][7:0]   enc;
        utf8_byte_t        item;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= unit;
        s_tuser  <= first;
        s_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        units_sent++;
        count = encode_unit(unit, first, last, enc);
        if (typed_count != FROM_PREDICTOR)
        begin
            count = typed_count;
            for (int k = 0; k < 3; k++)
            begin
                enc[k] = typed_bytes[23 - 8 * k -: 8];
            end
        end
        for (int k = 0; k < count; k++)
        begin
            item.data = enc[k];
            item.run_end = (k == count - 1);
            item.string_end = (k == count - 1) && last;
            utf8_expected.push_back(item);
        end
    endtask

    task automatic write_byte_order(input logic [1:0] value);
        while (utf8_expected.size() != 0)
        begin
            @(posedge clk);
        end
        // A held surrogate or a mark yields no byte, so give the block time to settle.
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        byte_order_mode = value;
    endtask

    function automatic logic [15:0] pick_text_unit();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = 16'($urandom_range(0, 16'h007f));
            3:       v = 16'($urandom_range(16'h0080, 16'h07ff));
            4, 5:
            begin
                v = 16'($urandom_range(16'h0800, 16'hffff));
                if (v >= 16'hd800 && v < 16'he000)
                begin
                    v = v ^ 16'h4000;
                end
            end
            6:       v = 16'($urandom_range(16'hdc00, 16'hdfff));
            default: v = 16'($urandom_range(0, 16'hffff));
        endcase
        return v;
    endfunction

    // Sends one string: an optional mark, then text laid out in the byte order
    // that the block is expected to pick for this string.
    task automatic send_string();
        logic [15:0] text [$];
        int          len;
        int          mark_kind;
        logic        swapped;
        logic        drop_last;
        logic [15:0] cu;
        logic [15:0] raw;
        text = {};
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                text.push_back(16'($urandom_range(16'hd800, 16'hdbff)));
                if ($urandom_range(0, 9) == 0)
                begin
                    text.push_back(16'($urandom_range(0, 16'hffff)));
                end
                else
                begin
                    text.push_back(16'($urandom_range(16'hdc00, 16'hdfff)));
                end
            end
            else
            begin
                text.push_back(pick_text_unit());
            end
        end
        if ($urandom_range(0, 5) == 0)
        begin
            text.push_back(16'($urandom_range(16'hd800, 16'hdbff)));
        end
        mark_kind = $urandom_range(0, 2);
        case (byte_order_mode)
            u16u8_pkg::MODE_LE: swapped = 1'b0;
            u16u8_pkg::MODE_BE: swapped = 1'b1;
            default:            swapped = (mark_kind != 1);
        endcase
        drop_last = ($urandom_range(0, 9) == 0);
        sender_burst = ($urandom_range(0, 3) == 0);
        if (mark_kind == 1)
        begin
            send_word(u16u8_pkg::BOM_NATIVE, 1'b1, 1'b0, FROM_PREDICTOR, 24'd0);
        end
        else if (mark_kind == 2)
        begin
            send_word(u16u8_pkg::BOM_SWAPPED, 1'b1, 1'b0, FROM_PREDICTOR, 24'd0);
        end
        for (int i = 0; i < text.size(); i++)
        begin
            cu = text[i];
            raw = swapped ? {cu[7:0], cu[15:8]} : cu;
            send_word(raw, (i == 0) && (mark_kind == 0),
                      (i == text.size() - 1) && !drop_last, FROM_PREDICTOR, 24'd0);
        end
    endtask

    task automatic run_random_phase(input int words);
        int target;
        target = units_sent + words;
        while (units_sent < target)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                sender_burst = 1'b0;
                send_word(16'($urandom_range(0, 16'hffff)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), FROM_PREDICTOR, 24'd0);
            end
            else
            begin
                send_string();
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // Byte sink: random ready with full-speed stretches, short stalls and,
    // on request, one long hold-off that lets the block back up.
    initial
    begin : byte_sink
        int stretch;
        stretch = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_holds++;
            end
            if (stretch > 0)
            begin
                stretch--;
                m_tready <= 1'b1;
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                stretch = $urandom_range(20, 80);
                m_tready <= 1'b1;
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(8, 30)) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge clk)
    begin
        utf8_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            bytes_checked++;
            if (utf8_expected.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h run_end %0b string_end %0b",
                                          m_tdata, m_tuser, m_tlast));
            end
            else
            begin
                want = utf8_expected.pop_front();
                if (m_tdata !== want.data || m_tuser !== want.run_end
                    || m_tlast !== want.string_end)
                begin
                    report_mismatch($sformatf(
                        "byte %02h/%02h run_end %0b/%0b string_end %0b/%0b (got/want)",
                        m_tdata, want.data, m_tuser, want.run_end,
                        m_tlast, want.string_end));
                end
            end
        end
    end

    // Ends the run if no word moves on any channel for too long.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
            if (idle >= IDLE_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles, %0d bytes outstanding",
                         IDLE_LIMIT, utf8_expected.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin : main_sequence
        // Directed rows run in detect mode straight after reset.
        directed_rows = '{
            '{16'h0041, 1'b0, 1'b0, 1, 24'h410000},           // before any first unit
            '{u16u8_pkg::BOM_SWAPPED, 1'b1, 1'b0, 0, 24'h000000}, // mark selects big-endian
            '{16'h4100, 1'b0, 1'b0, 1, 24'h410000},
            '{16'hffff, 1'b0, 1'b0, FROM_PREDICTOR, 24'h0},
            '{16'h0000, 1'b0, 1'b0, 1, 24'h000000},
            '{16'h8000, 1'b0, 1'b0, FROM_PREDICTOR, 24'h0},
            '{16'h00d8, 1'b0, 1'b0, 0, 24'h000000},           // high surrogate is held
            '{16'h00dc, 1'b0, 1'b0, FROM_PREDICTOR, 24'h0},
            '{16'h00dc, 1'b0, 1'b0, 3, 24'hefbfbd},           // lone low surrogate
            '{16'h3fdb, 1'b0, 1'b1, 3, 24'hefbfbd},           // high surrogate at string end
            '{u16u8_pkg::BOM_NATIVE, 1'b1, 1'b0, 0, 24'h000000},
            '{16'hdbff, 1'b0, 1'b0, 0, 24'h000000},
            '{16'h1234, 1'b0, 1'b1, FROM_PREDICTOR, 24'h0},   // unchecked second unit
            '{16'h00d8, 1'b1, 1'b0, 0, 24'h000000},           // no mark: big-endian
            '{u16u8_pkg::BOM_NATIVE, 1'b1, 1'b0, 0, 24'h000000}, // drops the held surrogate
            '{16'h0041, 1'b0, 1'b1, 1, 24'h410000},
            '{u16u8_pkg::BOM_SWAPPED, 1'b1, 1'b1, 0, 24'h000000}, // mark that is also last
            '{16'hffff, 1'b1, 1'b1, FROM_PREDICTOR, 24'h0},
            '{16'h7f00, 1'b0, 1'b0, 1, 24'h7f0000},
            '{16'hff07, 1'b0, 1'b0, FROM_PREDICTOR, 24'h0},
            '{16'hffdb, 1'b0, 1'b0, 0, 24'h000000},
            '{16'hffdf, 1'b0, 1'b1, FROM_PREDICTOR, 24'h0}
        };
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_burst = 1'b0;
        foreach (directed_rows[i])
        begin
            send_word(directed_rows[i].unit, directed_rows[i].first, directed_rows[i].last,
                      directed_rows[i].typed_count, directed_rows[i].typed_bytes);
        end
        s_tvalid <= 1'b0;

        write_byte_order(u16u8_pkg::MODE_LE);
        hold_request = 1'b1;
        run_random_phase(PHASE_WORDS);
        write_byte_order(u16u8_pkg::MODE_BE);
        run_random_phase(PHASE_WORDS);
        write_byte_order(MODE_SPARE);
        run_random_phase(PHASE_WORDS);
        write_byte_order(u16u8_pkg::MODE_DETECT);
        run_random_phase(PHASE_WORDS);

        while (utf8_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        $display("Summary: %0d code units in, %0d UTF-8 bytes checked, %0d mismatches.",
                 units_sent, bytes_checked, mismatches);
        $display("All four byte order mode values were used; long output hold-offs: %0d.",
                 long_holds);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: utf16_to_utf8_encoder_core.f
src/u16u8_pkg.sv
src/u16u8_front.sv
src/u16u8_queue.sv
src/u16u8_back.sv
src/utf16_to_utf8_encoder_core.sv
test/tb_utf16_to_utf8_encoder_core.sv
